### hdl/fei_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fei_pkg
// Shared widths, breakpoints, codes, types and helpers of the fuzzy
// evacuation inference core.
// ----------------------------------------------------------------------------
package fei_pkg;

   localparam int IN_W      = 12;
   localparam int MEMB_W    = 10;
   localparam int LEVEL_W   = 6;
   localparam int CODE_W    = 2;
   localparam int RULES     = 9;
   localparam int MEMBS     = 3;
   localparam int MAP_W     = RULES * CODE_W;
   localparam int PROD_W    = MEMB_W + LEVEL_W;
   localparam int TOP_W     = 19;
   localparam int BOT_W     = 13;
   localparam int Q_W       = 14;
   localparam int FRAC_W    = 8;
   localparam int STEPS_PER_STAGE = 2;
   localparam int DIV_STAGES = Q_W / STEPS_PER_STAGE;
   localparam int LOW_TOP_W = Q_W - FRAC_W;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = MAP_W;

   localparam logic [MEMB_W-1:0] ONE_MEMB = 10'd640;

   // Breakpoints: 0.5/1.0/1.5 V in Q4.8, 10/20/30 s in Q8.4
   localparam logic [IN_W-1:0] V_LO  = 12'd128;
   localparam logic [IN_W-1:0] V_MID = 12'd256;
   localparam logic [IN_W-1:0] V_HI  = 12'd384;
   localparam logic [IN_W-1:0] D_LO  = 12'd160;
   localparam logic [IN_W-1:0] D_MID = 12'd320;
   localparam logic [IN_W-1:0] D_HI  = 12'd480;
   localparam logic [2:0]      V_SLOPE = 3'd5;
   localparam logic [2:0]      D_SLOPE = 3'd4;

   localparam logic [LEVEL_W-1:0] FAST_RESET    = 6'd5;
   localparam logic [LEVEL_W-1:0] AVERAGE_RESET = 6'd10;
   localparam logic [LEVEL_W-1:0] SLOW_RESET    = 6'd15;
   localparam logic [MAP_W-1:0]   MAP_RESET     = 18'd66601;

   typedef logic [MEMB_W-1:0] memb_type;
   typedef memb_type [MEMBS-1:0] memb_vec_type;

   typedef enum logic [CODE_W-1:0] {
      CODE_FAST,
      CODE_AVERAGE,
      CODE_SLOW,
      CODE_ZERO
   } level_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FAST_LEVEL,
      CSR_AVERAGE_LEVEL,
      CSR_SLOW_LEVEL,
      CSR_RULE_MAP
   } csr_index_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] fast_level;
      logic [LEVEL_W-1:0] average_level;
      logic [LEVEL_W-1:0] slow_level;
      logic [MAP_W-1:0]   rule_map;
   } cfg_type;

   typedef struct packed {
      logic [BOT_W-1:0] rem;
      logic             qbit;
   } div_step_type;

   // Triangular fuzzification into three memberships on the 640 scale
   function automatic memb_vec_type fuzzify(input logic [IN_W-1:0] x,
                                            input logic [IN_W-1:0] lo,
                                            input logic [IN_W-1:0] mid,
                                            input logic [IN_W-1:0] hi,
                                            input logic [2:0] k);
      memb_vec_type m;
      logic [IN_W-1:0] d;
      logic [IN_W+2:0] t;
      m = '0;
      d = '0;
      t = '0;
      if (x <= lo) begin
         m[0] = ONE_MEMB;
      end
      if (x > lo && x < mid) begin
         d = mid - x;
         t = (IN_W+3)'(k) * (IN_W+3)'(d);
         m[0] = t[MEMB_W-1:0];
      end
      if (x > lo && x <= mid) begin
         d = x - lo;
         t = (IN_W+3)'(k) * (IN_W+3)'(d);
         m[1] = t[MEMB_W-1:0];
      end
      if (x > mid && x < hi) begin
         d = hi - x;
         t = (IN_W+3)'(k) * (IN_W+3)'(d);
         m[1] = t[MEMB_W-1:0];
      end
      if (x > mid && x <= hi) begin
         d = x - mid;
         t = (IN_W+3)'(k) * (IN_W+3)'(d);
         m[2] = t[MEMB_W-1:0];
      end
      if (x > hi) begin
         m[2] = ONE_MEMB;
      end
      return m;
   endfunction

   // One restoring division step: shift in a dividend bit, subtract if it fits
   function automatic div_step_type div_step(input logic [BOT_W-1:0] rem,
                                             input logic [BOT_W-1:0] bot,
                                             input logic din);
      div_step_type res;
      logic [BOT_W:0] sh;
      sh = {rem, din};
      if (sh >= {1'b0, bot}) begin
         res.rem  = BOT_W'(sh - {1'b0, bot});
         res.qbit = 1'b1;
      end else begin
         res.rem  = sh[BOT_W-1:0];
         res.qbit = 1'b0;
      end
      return res;
   endfunction

endpackage
`default_nettype wire

### hdl/fei_fuzzify.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fei_fuzzify
// First pipeline stage: both inputs fuzzified into three memberships each.
// ----------------------------------------------------------------------------
module fei_fuzzify (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   output logic                           in_ready,
   input  wire logic [fei_pkg::IN_W-1:0]  intensity_volts,
   input  wire logic [fei_pkg::IN_W-1:0]  delay_seconds,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output fei_pkg::memb_vec_type          memb_v,
   output fei_pkg::memb_vec_type          memb_d
);

   logic                  valid_ff;
   fei_pkg::memb_vec_type mv_ff, mv_in;
   fei_pkg::memb_vec_type md_ff, md_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      mv_in = fei_pkg::fuzzify(intensity_volts, fei_pkg::V_LO, fei_pkg::V_MID,
                               fei_pkg::V_HI, fei_pkg::V_SLOPE);
      md_in = fei_pkg::fuzzify(delay_seconds, fei_pkg::D_LO, fei_pkg::D_MID,
                               fei_pkg::D_HI, fei_pkg::D_SLOPE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         mv_ff <= mv_in;
         md_ff <= md_in;
      end
   end

   assign out_valid = valid_ff;
   assign memb_v    = mv_ff;
   assign memb_d    = md_ff;

endmodule
`default_nettype wire

### hdl/fei_rules.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fei_rules
// Rule evaluation over three stages: strengths and levels, products, sums.
// ----------------------------------------------------------------------------
module fei_rules (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire fei_pkg::cfg_type           cfg,
   input  wire logic                       in_valid,
   output logic                            in_ready,
   input  wire fei_pkg::memb_vec_type      memb_v,
   input  wire fei_pkg::memb_vec_type      memb_d,
   output logic                            out_valid,
   input  wire logic                       out_ready,
   output logic [fei_pkg::TOP_W-1:0]       top,
   output logic [fei_pkg::BOT_W-1:0]       bot
);

   localparam int R = fei_pkg::RULES;

   logic [2:0] valid_ff;
   logic [2:0] ready;

   logic [fei_pkg::MEMB_W-1:0]  w_ff  [R];
   logic [fei_pkg::MEMB_W-1:0]  w_in  [R];
   logic [fei_pkg::LEVEL_W-1:0] lv_ff [R];
   logic [fei_pkg::LEVEL_W-1:0] lv_in [R];
   logic [fei_pkg::MEMB_W-1:0]  wb_ff [R];
   logic [fei_pkg::PROD_W-1:0]  prod_ff [R];
   logic [fei_pkg::PROD_W-1:0]  prod_in [R];
   logic [fei_pkg::TOP_W-1:0]   top_ff, top_in;
   logic [fei_pkg::BOT_W-1:0]   bot_ff, bot_in;

   assign ready[2] = !valid_ff[2] || out_ready;
   assign ready[1] = !valid_ff[1] || ready[2];
   assign ready[0] = !valid_ff[0] || ready[1];
   assign in_ready = ready[0];

   // Strengths are pairwise minima; rule 3p+q pairs intensity p with delay q
   always_comb begin
      fei_pkg::level_code_type code;
      for (int i = 0; i < R; i++) begin
         w_in[i] = (memb_v[i/3] < memb_d[i%3]) ? memb_v[i/3] : memb_d[i%3];
         code = fei_pkg::level_code_type'(cfg.rule_map[2*i +: fei_pkg::CODE_W]);
         unique case (code)
            fei_pkg::CODE_FAST:    lv_in[i] = cfg.fast_level;
            fei_pkg::CODE_AVERAGE: lv_in[i] = cfg.average_level;
            fei_pkg::CODE_SLOW:    lv_in[i] = cfg.slow_level;
            fei_pkg::CODE_ZERO:    lv_in[i] = '0;
            default:               lv_in[i] = '0;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < R; i++) begin
         prod_in[i] = fei_pkg::PROD_W'(w_ff[i]) * fei_pkg::PROD_W'(lv_ff[i]);
      end
   end

   always_comb begin
      top_in = '0;
      bot_in = '0;
      for (int i = 0; i < R; i++) begin
         top_in = top_in + fei_pkg::TOP_W'(prod_ff[i]);
         bot_in = bot_in + fei_pkg::BOT_W'(wb_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) valid_ff[0] <= in_valid;
         if (ready[1]) valid_ff[1] <= valid_ff[0];
         if (ready[2]) valid_ff[2] <= valid_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0] && in_valid) begin
         w_ff  <= w_in;
         lv_ff <= lv_in;
      end
      if (ready[1] && valid_ff[0]) begin
         prod_ff <= prod_in;
         wb_ff   <= w_ff;
      end
      if (ready[2] && valid_ff[1]) begin
         top_ff <= top_in;
         bot_ff <= bot_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign top       = top_ff;
   assign bot       = bot_ff;

endmodule
`default_nettype wire

### hdl/fei_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fei_divider
// Pipelined restoring divider: floor(256*top/bot), two quotient bits a stage.
// ----------------------------------------------------------------------------
module fei_divider (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire logic [fei_pkg::TOP_W-1:0] top,
   input  wire logic [fei_pkg::BOT_W-1:0] bot,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output logic [fei_pkg::Q_W-1:0]       quotient,
   output logic                          no_rule_fired
);

   localparam int S  = fei_pkg::DIV_STAGES;
   localparam int BW = fei_pkg::BOT_W;
   localparam int QW = fei_pkg::Q_W;

   logic [S-1:0]  valid_ff;
   logic [S-1:0]  ready;
   logic [BW-1:0] rem_ff  [S];
   logic [BW-1:0] bot_ff  [S];
   logic [QW-1:0] dd_ff   [S];
   logic [QW-1:0] q_ff    [S];
   logic [S-1:0]  none_ff;

   logic [BW-1:0] src_rem  [S];
   logic [BW-1:0] src_bot  [S];
   logic [QW-1:0] src_dd   [S];
   logic [QW-1:0] src_q    [S];
   logic [S-1:0]  src_none;
   logic [S-1:0]  src_valid;

   logic [BW-1:0] rem_in [S];
   logic [QW-1:0] dd_in  [S];
   logic [QW-1:0] q_in   [S];

   // Quotient stays below 2^14, so top>>6 is already below bot
   assign src_rem[0]   = top[fei_pkg::TOP_W-1:fei_pkg::LOW_TOP_W];
   assign src_bot[0]   = bot;
   assign src_dd[0]    = {top[fei_pkg::LOW_TOP_W-1:0], {fei_pkg::FRAC_W{1'b0}}};
   assign src_q[0]     = '0;
   assign src_none[0]  = (bot == '0);
   assign src_valid[0] = in_valid;
   assign in_ready     = ready[0];

   for (genvar j = 0; j < S; j++) begin : g_stage
      if (j > 0) begin : g_link
         assign src_rem[j]   = rem_ff[j-1];
         assign src_bot[j]   = bot_ff[j-1];
         assign src_dd[j]    = dd_ff[j-1];
         assign src_q[j]     = q_ff[j-1];
         assign src_none[j]  = none_ff[j-1];
         assign src_valid[j] = valid_ff[j-1];
      end
      if (j == S - 1) begin : g_last
         assign ready[j] = !valid_ff[j] || out_ready;
      end else begin : g_mid
         assign ready[j] = !valid_ff[j] || ready[j+1];
      end

      always_comb begin
         fei_pkg::div_step_type st;
         rem_in[j] = src_rem[j];
         dd_in[j]  = src_dd[j];
         q_in[j]   = src_q[j];
         for (int k = 0; k < fei_pkg::STEPS_PER_STAGE; k++) begin
            st        = fei_pkg::div_step(rem_in[j], src_bot[j], dd_in[j][QW-1]);
            rem_in[j] = st.rem;
            dd_in[j]  = {dd_in[j][QW-2:0], 1'b0};
            q_in[j]   = {q_in[j][QW-2:0], st.qbit};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (ready[j]) begin
            valid_ff[j] <= src_valid[j];
         end
      end

      always_ff @(posedge clock) begin
         if (ready[j] && src_valid[j]) begin
            rem_ff[j]  <= rem_in[j];
            bot_ff[j]  <= src_bot[j];
            dd_ff[j]   <= dd_in[j];
            q_ff[j]    <= q_in[j];
            none_ff[j] <= src_none[j];
         end
      end
   end

   assign out_valid     = valid_ff[S-1];
   assign no_rule_fired = none_ff[S-1];
   assign quotient      = none_ff[S-1] ? '0 : q_ff[S-1];

endmodule
`default_nettype wire

### hdl/fuzzy_evacuation_inference_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fuzzy_evacuation_inference_core
// Two-input 3x3 Sugeno fuzzy inference giving a Q6.8 evacuation estimate.
// ----------------------------------------------------------------------------
// Takes one word per clock while req_stall is low (sensor voltage in Q4.8
// volts, delay in Q8.4 seconds) and returns one result word per input word,
// in order. In the datapath one stage fuzzifies both inputs, three stages
// form the nine rule strengths and levels, their products and the two sums,
// and a seven-stage restoring divider yields two quotient bits a stage. Every
// stage holds its own valid bit and advances when the one after it has room,
// so bubbles close up, and a stall on the result side reaches back through
// the combinational ready chain to every full stage; the last divider stage
// serves as the output register. The result is
// floor(256 * sum(strength*level) / sum(strength)) truncated to 14 bits;
// no_rule_fired flags a zero strength sum and forces the value to zero.
// Write the four level and map registers only while no word is in flight.
// ----------------------------------------------------------------------------
module fuzzy_evacuation_inference_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // configuration
   input  wire logic                             csr_write_enable,
   input  wire logic [fei_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [fei_pkg::CSR_DATA_W-1:0]   csr_write_data,
   // request channel
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [fei_pkg::IN_W-1:0]         req_intensity_volts,
   input  wire logic [fei_pkg::IN_W-1:0]         req_delay_seconds,
   // response channel
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [fei_pkg::Q_W-1:0]               rsp_evacuation_value,
   output logic                                  rsp_no_rule_fired
);

   fei_pkg::cfg_type cfg_ff;

   logic                       fz_ready;
   logic                       fz_valid;
   fei_pkg::memb_vec_type      memb_v;
   fei_pkg::memb_vec_type      memb_d;
   logic                       ru_ready;
   logic                       ru_valid;
   logic [fei_pkg::TOP_W-1:0]  top;
   logic [fei_pkg::BOT_W-1:0]  bot;
   logic                       dv_ready;

   // Configuration registers: mask each write to the register's width
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fast_level    <= fei_pkg::FAST_RESET;
         cfg_ff.average_level <= fei_pkg::AVERAGE_RESET;
         cfg_ff.slow_level    <= fei_pkg::SLOW_RESET;
         cfg_ff.rule_map      <= fei_pkg::MAP_RESET;
      end else if (csr_write_enable) begin
         unique case (fei_pkg::csr_index_type'(csr_index))
            fei_pkg::CSR_FAST_LEVEL:
               cfg_ff.fast_level <= csr_write_data[fei_pkg::LEVEL_W-1:0];
            fei_pkg::CSR_AVERAGE_LEVEL:
               cfg_ff.average_level <= csr_write_data[fei_pkg::LEVEL_W-1:0];
            fei_pkg::CSR_SLOW_LEVEL:
               cfg_ff.slow_level <= csr_write_data[fei_pkg::LEVEL_W-1:0];
            fei_pkg::CSR_RULE_MAP:
               cfg_ff.rule_map <= csr_write_data[fei_pkg::MAP_W-1:0];
            default: ;
         endcase
      end
   end

   // Stall the request side whenever the fuzzify stage cannot advance
   assign req_stall = !fz_ready;

   fei_fuzzify u_fuzzify (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_valid),
      .in_ready        (fz_ready),
      .intensity_volts (req_intensity_volts),
      .delay_seconds   (req_delay_seconds),
      .out_valid       (fz_valid),
      .out_ready       (ru_ready),
      .memb_v          (memb_v),
      .memb_d          (memb_d)
   );

   fei_rules u_rules (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (fz_valid),
      .in_ready  (ru_ready),
      .memb_v    (memb_v),
      .memb_d    (memb_d),
      .out_valid (ru_valid),
      .out_ready (dv_ready),
      .top       (top),
      .bot       (bot)
   );

   fei_divider u_divider (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (ru_valid),
      .in_ready      (dv_ready),
      .top           (top),
      .bot           (bot),
      .out_valid     (rsp_valid),
      .out_ready     (!rsp_stall),
      .quotient      (rsp_evacuation_value),
      .no_rule_fired (rsp_no_rule_fired)
   );

endmodule
`default_nettype wire

### hdl/fei_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fei_checker
// Port-level checks of the fuzzy evacuation inference core, bound to it.
// ----------------------------------------------------------------------------
module fei_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire logic [fei_pkg::Q_W-1:0]        rsp_evacuation_value,
   input wire logic                           rsp_no_rule_fired
);

   localparam logic [fei_pkg::Q_W-1:0] MAX_VALUE = 14'd16128;

   // Hold a stalled response word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         $stable(rsp_evacuation_value) && $stable(rsp_no_rule_fired))
      else $error("stalled response word changed");

   // Memberships of each input sum to one, so some rule always fires
   a_rule_fires: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_no_rule_fired)
      else $error("no rule fired");

   // A weighted average cannot exceed the largest level
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_evacuation_value <= MAX_VALUE)
      else $error("evacuation value above largest level");

   a_reset_idle: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response word straight after reset");

endmodule

bind fuzzy_evacuation_inference_core fei_checker u_fei_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_evacuation_value (rsp_evacuation_value),
   .rsp_no_rule_fired    (rsp_no_rule_fired)
);
`default_nettype wire
